// ===== src/cgla_pkg.sv =====
// Package for the commit graph lane allocator.
// Holds lane and id widths, item kind codes and the control/status structs.
// Used by every module and interface of the block.
`timescale 1ns / 1ps

package cgla_pkg;

	localparam int MAX_LANES  = 64;
	localparam int LANE_W     = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
	localparam int LANE_OUT_W = 6;
	localparam int OP_W       = 2;
	localparam int KEY_HI_W   = 64;
	localparam int KEY_MID_W  = 64;
	localparam int KEY_LO_W   = 32;
	localparam int KEY_W      = KEY_HI_W + KEY_MID_W + KEY_LO_W;

	localparam logic [OP_W-1:0] OP_BEGIN  = 2'd0;
	localparam logic [OP_W-1:0] OP_PARENT = 2'd1;
	localparam logic [OP_W-1:0] OP_END    = 2'd2;

	typedef logic [LANE_W-1:0] lane_idx_t;
	typedef logic [KEY_W-1:0]  key_t;

	// Controller to datapath
	typedef struct packed {
		logic      start;   // latch the accepted item, clear search results
		logic      issue;   // read one pending entry
		lane_idx_t addr;    // entry to read
		logic      commit;  // apply the item and load the result register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic needs_scan;   // the incoming item must search the pending ids
	} status_t;

	function automatic logic [LANE_OUT_W-1:0] to_out_lane(input lane_idx_t l);
		return LANE_OUT_W'(l);
	endfunction

endpackage

// ===== src/cgla_req_if.sv =====
// Input channel of the lane allocator: valid/ready plus one history item.
// Depends on cgla_pkg for field widths.
`timescale 1ns / 1ps

interface cgla_req_if;
	logic                           valid;
	logic                           ready;
	logic [cgla_pkg::OP_W-1:0]      op;
	logic [cgla_pkg::KEY_HI_W-1:0]  key_hi;
	logic [cgla_pkg::KEY_MID_W-1:0] key_mid;
	logic [cgla_pkg::KEY_LO_W-1:0]  key_lo;
	logic                           first_parent;

	modport source (output valid, op, key_hi, key_mid, key_lo, first_parent, input ready);
	modport sink (input valid, op, key_hi, key_mid, key_lo, first_parent, output ready);
endinterface

// ===== src/cgla_rsp_if.sv =====
// Output channel of the lane allocator: valid/ready plus one result item.
// Depends on cgla_pkg for field widths.
`timescale 1ns / 1ps

interface cgla_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [cgla_pkg::LANE_OUT_W-1:0] lane;
	logic                            assigned;
	logic                            lane_freed;
	logic                            full_res;

	modport source (output valid, lane, assigned, lane_freed, full_res, input ready);
	modport sink (input valid, lane, assigned, lane_freed, full_res, output ready);
endinterface

// ===== src/cgla_ctrl.sv =====
// Controller of the lane allocator: item sequencing, scan counter, output valid.
// Depends on cgla_pkg for the command and status structs.
`timescale 1ns / 1ps

module cgla_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	input  cgla_pkg::status_t  status,
	output cgla_pkg::cmd_t     cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_FIN   = 4'b1000
	} state_t;

	state_t              state_q, state_d;
	cgla_pkg::lane_idx_t cnt_q;
	logic                rsp_valid_q;
	logic                accept;
	logic                last_addr;
	logic                can_commit;

	assign req_ready  = (state_q == ST_IDLE);
	assign accept     = req_valid && req_ready;
	assign last_addr  = (cnt_q == cgla_pkg::LANE_W'(cgla_pkg::MAX_LANES - 1));
	assign can_commit = !rsp_valid_q || rsp_ready;
	assign rsp_valid  = rsp_valid_q;

	always_comb begin
		state_d    = state_q;
		cmd.start  = 1'b0;
		cmd.issue  = 1'b0;
		cmd.addr   = cnt_q;
		cmd.commit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.start = 1'b1;
					state_d   = status.needs_scan ? ST_SCAN : ST_FIN;
				end
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
				if (last_addr) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				// last compare happens here
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (can_commit) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.start) cnt_q <= '0;
			else if (cmd.issue) cnt_q <= cnt_q + 1'b1;
			if (cmd.commit) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

endmodule

// ===== src/cgla_dp.sv =====
// Datapath of the lane allocator: pending id memory, valid bits, commit state,
// scan compare and result register. Depends on cgla_pkg.
`timescale 1ns / 1ps

module cgla_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [cgla_pkg::OP_W-1:0]           op,
	input  logic [cgla_pkg::KEY_HI_W-1:0]       key_hi,
	input  logic [cgla_pkg::KEY_MID_W-1:0]      key_mid,
	input  logic [cgla_pkg::KEY_LO_W-1:0]       key_lo,
	input  logic                                first_parent,
	input  cgla_pkg::cmd_t                      cmd,
	output cgla_pkg::status_t                   status,
	output logic [cgla_pkg::LANE_OUT_W-1:0]     lane,
	output logic                                assigned,
	output logic                                lane_freed,
	output logic                                full_res
);

	// pending ids, undefined until written
	cgla_pkg::key_t mem [cgla_pkg::MAX_LANES];

	logic [cgla_pkg::MAX_LANES-1:0] valid_q;
	cgla_pkg::lane_idx_t            cur_lane_q;
	logic                           active_q;
	logic                           ext_q;

	logic [cgla_pkg::OP_W-1:0] op_q;
	cgla_pkg::key_t            key_q;
	logic                      fp_q;

	logic                rd_vld_s1;
	cgla_pkg::lane_idx_t rd_idx_s1;
	cgla_pkg::key_t      rd_key_s1;

	logic                hit_found_q, free_found_q;
	cgla_pkg::lane_idx_t hit_idx_q, free_idx_q;

	logic [cgla_pkg::LANE_OUT_W-1:0] lane_q;
	logic                            assigned_q, freed_q, full_q;

	logic                is_match, is_free;
	cgla_pkg::lane_idx_t res_lane;
	logic                res_asg, res_freed, res_full;
	logic                wr_en, clr_en;
	cgla_pkg::lane_idx_t wr_idx;
	logic                nxt_active, nxt_ext;
	cgla_pkg::lane_idx_t nxt_cur;

	assign status.needs_scan = (op == cgla_pkg::OP_BEGIN) ||
		((op == cgla_pkg::OP_PARENT) && active_q);

	assign is_match = valid_q[rd_idx_s1] && (rd_key_s1 == key_q);
	// a parent search skips the commit's own lane
	assign is_free  = !valid_q[rd_idx_s1] &&
		!((op_q == cgla_pkg::OP_PARENT) && (rd_idx_s1 == cur_lane_q));

	always_comb begin
		res_lane   = '0;
		res_asg    = 1'b0;
		res_freed  = 1'b0;
		res_full   = 1'b0;
		wr_en      = 1'b0;
		wr_idx     = cur_lane_q;
		clr_en     = 1'b0;
		nxt_active = active_q;
		nxt_ext    = ext_q;
		nxt_cur    = cur_lane_q;
		case (op_q)
			cgla_pkg::OP_BEGIN: begin
				nxt_ext = 1'b0;
				if (hit_found_q) begin
					clr_en     = 1'b1;
					nxt_cur    = hit_idx_q;
					nxt_active = 1'b1;
					res_lane   = hit_idx_q;
					res_asg    = 1'b1;
				end else if (free_found_q) begin
					nxt_cur    = free_idx_q;
					nxt_active = 1'b1;
					res_lane   = free_idx_q;
					res_asg    = 1'b1;
				end else begin
					nxt_active = 1'b0;
					res_full   = 1'b1;
				end
			end
			cgla_pkg::OP_PARENT: begin
				if (active_q) begin
					if (hit_found_q) begin
						res_lane = hit_idx_q;
					end else if (fp_q && !ext_q) begin
						wr_en    = 1'b1;
						nxt_ext  = 1'b1;
						res_lane = cur_lane_q;
						res_asg  = 1'b1;
					end else if (free_found_q) begin
						wr_en    = 1'b1;
						wr_idx   = free_idx_q;
						res_lane = free_idx_q;
						res_asg  = 1'b1;
					end else begin
						res_full = 1'b1;
					end
				end
			end
			cgla_pkg::OP_END: begin
				if (active_q) begin
					res_lane   = cur_lane_q;
					res_freed  = !ext_q;
					nxt_active = 1'b0;
					nxt_ext    = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	// pending id memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.commit && wr_en) mem[wr_idx] <= key_q;
		if (cmd.issue) rd_key_s1 <= mem[cmd.addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			cur_lane_q   <= '0;
			active_q     <= 1'b0;
			ext_q        <= 1'b0;
			rd_vld_s1    <= 1'b0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.issue;
			if (cmd.start) begin
				hit_found_q  <= 1'b0;
				free_found_q <= 1'b0;
			end else if (rd_vld_s1) begin
				// keep the lowest lane of each kind
				if (is_match && !hit_found_q) hit_found_q <= 1'b1;
				if (is_free && !free_found_q) free_found_q <= 1'b1;
			end
			if (cmd.commit) begin
				cur_lane_q <= nxt_cur;
				active_q   <= nxt_active;
				ext_q      <= nxt_ext;
				if (clr_en) valid_q[hit_idx_q] <= 1'b0;
				if (wr_en) valid_q[wr_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q  <= op;
			key_q <= {key_hi, key_mid, key_lo};
			fp_q  <= first_parent;
		end
		if (cmd.issue) rd_idx_s1 <= cmd.addr;
		if (rd_vld_s1 && is_match && !hit_found_q) hit_idx_q <= rd_idx_s1;
		if (rd_vld_s1 && is_free && !free_found_q) free_idx_q <= rd_idx_s1;
		if (cmd.commit) begin
			lane_q     <= cgla_pkg::to_out_lane(res_lane);
			assigned_q <= res_asg;
			freed_q    <= res_freed;
			full_q     <= res_full;
		end
	end

	assign lane       = lane_q;
	assign assigned   = assigned_q;
	assign lane_freed = freed_q;
	assign full_res   = full_q;

endmodule

// ===== src/commit_graph_lane_allocator_top.sv =====
// Commit graph lane allocator, top level.
// Channels: req carries one history item (op, 160-bit id in key_hi/key_mid/
// key_lo, first_parent); rsp carries one result per item (lane, assigned,
// lane_freed, full_res). Both channels move an item when valid and ready are
// high at a rising edge of clk.
// Search: commit begin, and parent while a commit is active, search all
// MAX_LANES pending ids through the single read port of the id memory, one
// entry a cycle; such an item is accepted, scanned, drained and committed
// before the next item is accepted. Other items (commit end, parent with
// no active commit, unused op) skip the scan and go straight to commit.
// rsp.valid rises from the output register, which is loaded at commit, after
// the item's states (scan and drain for a searching item) have run.
// req.ready is high whenever no item is in work; a finished result waits in
// the output register while the next item is accepted and searched. If the
// receiver stalls, the following item holds its finished state until the
// output register frees, and req.ready stays low meanwhile.
// Reset (arst_n low, asynchronous) clears all pending valid bits, the active
// commit and the output valid; the id memory needs no clearing pass.
// Depends on cgla_pkg, cgla_req_if, cgla_rsp_if, cgla_ctrl and cgla_dp.
`timescale 1ns / 1ps

module commit_graph_lane_allocator_top (
	input  logic       clk,
	input  logic       arst_n,
	cgla_req_if.sink   req,
	cgla_rsp_if.source rsp
);

	cgla_pkg::cmd_t    cmd;
	cgla_pkg::status_t status;

	cgla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	cgla_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (req.op),
		.key_hi       (req.key_hi),
		.key_mid      (req.key_mid),
		.key_lo       (req.key_lo),
		.first_parent (req.first_parent),
		.cmd          (cmd),
		.status       (status),
		.lane         (rsp.lane),
		.assigned     (rsp.assigned),
		.lane_freed   (rsp.lane_freed),
		.full_res     (rsp.full_res)
	);

endmodule
